// ===== sv/c2zp_pkg.sv =====
// ----------------------------------------------------------------------------
// c2zp_pkg
// shared constants, register indexes and types of the 2x2 zero padded filter
// ----------------------------------------------------------------------------
package c2zp_pkg;

    // line buffer depth and derived widths
    localparam int MAX_SIZE = 1024;
    localparam int ADDR_W   = $clog2(MAX_SIZE);
    localparam int IMG_W    = 11;
    localparam int CNT_W    = (ADDR_W + 1 > IMG_W) ? ADDR_W + 1 : IMG_W;

    // payload widths
    localparam int PIX_W  = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = PIX_W + COEF_W;
    localparam int OUT_W  = 34;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP_LEFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LEFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER   = 3'd4;

    localparam logic [IMG_W-1:0]  IMAGE_SIZE_RESET = 11'd4;
    localparam logic [COEF_W-1:0] COEF_RESET       = 16'd256;

    // four kernel weights
    typedef struct packed {
        logic signed [COEF_W-1:0] top_left;
        logic signed [COEF_W-1:0] top;
        logic signed [COEF_W-1:0] left;
        logic signed [COEF_W-1:0] center;
    } coef_set_t;

    // raster position of the next beat
    typedef struct packed {
        logic [ADDR_W-1:0] col;
        logic              row_nz;
        logic              col_nz;
        logic              done;
    } raster_t;

    // neighborhood of one pixel, with in-image flags
    typedef struct packed {
        logic signed [PIX_W-1:0] above_left;
        logic signed [PIX_W-1:0] above;
        logic signed [PIX_W-1:0] left;
        logic signed [PIX_W-1:0] center;
        logic                    row_nz;
        logic                    col_nz;
    } taps_t;

endpackage

// ===== sv/c2zp_ram.sv =====
// ----------------------------------------------------------------------------
// c2zp_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module c2zp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/c2zp_raster.sv =====
// ----------------------------------------------------------------------------
// c2zp_raster
// row and column counters that follow the configured image size
// ----------------------------------------------------------------------------
module c2zp_raster (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [c2zp_pkg::IMG_W-1:0]   image_size,
    output c2zp_pkg::raster_t            pos
);
    import c2zp_pkg::*;

    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ADDR_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0]  size_raw;
    logic [CNT_W-1:0]  size_eff;
    logic              col_wrap;
    logic              row_wrap;

    // zero acts as one, oversize clamps to the buffer depth
    always_comb begin
        size_raw = CNT_W'(image_size);
        if (size_raw == '0) begin
            size_eff = CNT_W'(1);
        end else if (size_raw > CNT_W'(MAX_SIZE)) begin
            size_eff = CNT_W'(MAX_SIZE);
        end else begin
            size_eff = size_raw;
        end
    end

    assign col_wrap = (CNT_W'(col_reg) + CNT_W'(1)) >= size_eff;
    assign row_wrap = (CNT_W'(row_reg) + CNT_W'(1)) >= size_eff;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap) begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + ADDR_W'(1);
        end else begin
            col_next = col_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.col    = col_reg;
    assign pos.row_nz = (row_reg != '0);
    assign pos.col_nz = (col_reg != '0);
    assign pos.done   = col_wrap && row_wrap;

    // last pixel of the image always brings both counters home
    a_done_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && pos.done |=> col_reg == '0 && row_reg == '0)
        else $error("counters not cleared after last pixel");

endmodule

// ===== sv/c2zp_mac.sv =====
// ----------------------------------------------------------------------------
// c2zp_mac
// four weighted taps summed at full width, out-of-image taps forced to zero
// ----------------------------------------------------------------------------
module c2zp_mac (
    input  c2zp_pkg::coef_set_t                 coefs,
    input  c2zp_pkg::taps_t                     taps,
    output logic signed [c2zp_pkg::OUT_W-1:0]   result
);
    import c2zp_pkg::*;

    logic signed [PROD_W-1:0] p_tl, p_t, p_l, p_c;
    logic signed [PROD_W-1:0] t_tl, t_t, t_l;

    assign p_tl = coefs.top_left * taps.above_left;
    assign p_t  = coefs.top      * taps.above;
    assign p_l  = coefs.left     * taps.left;
    assign p_c  = coefs.center   * taps.center;

    // zero padding
    assign t_tl = (taps.row_nz && taps.col_nz) ? p_tl : '0;
    assign t_t  = taps.row_nz ? p_t : '0;
    assign t_l  = taps.col_nz ? p_l : '0;

    assign result = OUT_W'(t_tl) + OUT_W'(t_t) + OUT_W'(t_l) + OUT_W'(p_c);

endmodule

// ===== sv/conv2x2_zero_pad_stream.sv =====
// ----------------------------------------------------------------------------
// conv2x2_zero_pad_stream
// streaming 2x2 convolution over a square raster image with zero padding
//
//   channel  dir  ports                          per beat
//   s_       in   s_valid s_ready s_pixel        one Q8.8 pixel, raster order
//   m_       out  m_valid m_ready m_filtered     one Q18.16 result per pixel
//                 m_image_done                   high on the last pixel
//   cfg_     in   cfg_we cfg_index cfg_data      register write, no wait
//
// one beat per clock sustained while m_ready is high; a pixel reaches m_ via
// the input stage with its line buffer read, then the result register.
// reset is synchronous and clears counters, valids, config and neighbor regs;
// the line buffer needs no clearing pass, as row zero ignores what it reads.
// a stall at m_ holds the result register and then the input stage, and
// s_ready drops only when both are full.
// ----------------------------------------------------------------------------
module conv2x2_zero_pad_stream (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // pixel input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [c2zp_pkg::PIX_W-1:0]     s_pixel,
    // result output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [c2zp_pkg::OUT_W-1:0]     m_filtered,
    output logic                                  m_image_done,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [c2zp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [c2zp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import c2zp_pkg::*;

    // configuration registers
    logic [IMG_W-1:0] image_size_reg;
    coef_set_t        coefs_reg;

    // handshake
    logic s_accept;
    logic s1_adv;

    // input stage: pixel, its position, and the line buffer bypass
    logic                    s1_valid_reg;
    logic signed [PIX_W-1:0] s1_pixel_reg;
    logic [ADDR_W-1:0]       s1_col_reg;
    logic                    s1_row_nz_reg;
    logic                    s1_col_nz_reg;
    logic                    s1_done_reg;
    logic                    s1_fwd_reg;
    logic signed [PIX_W-1:0] s1_fwd_pix_reg;

    // neighbors left behind by the previous pixel
    logic signed [PIX_W-1:0] left_reg;
    logic signed [PIX_W-1:0] above_left_reg;

    // result register
    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] m_filtered_reg;
    logic                    m_done_reg;

    raster_t                 pos;
    taps_t                   taps;
    logic [PIX_W-1:0]        ram_rdata;
    logic signed [PIX_W-1:0] above_raw;
    logic signed [OUT_W-1:0] mac_result;

    // ------------------------------------------------------------------
    // configuration port, unknown indexes fall through and are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg     <= IMAGE_SIZE_RESET;
            coefs_reg.top_left <= COEF_RESET;
            coefs_reg.top      <= COEF_RESET;
            coefs_reg.left     <= COEF_RESET;
            coefs_reg.center   <= COEF_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_SIZE:    image_size_reg     <= cfg_data[IMG_W-1:0];
                CFG_COEF_TOP_LEFT: coefs_reg.top_left <= cfg_data[COEF_W-1:0];
                CFG_COEF_TOP:      coefs_reg.top      <= cfg_data[COEF_W-1:0];
                CFG_COEF_LEFT:     coefs_reg.left     <= cfg_data[COEF_W-1:0];
                CFG_COEF_CENTER:   coefs_reg.center   <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: the input stage moves on when the result slot frees up
    // ------------------------------------------------------------------
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    // raster counters step on every accepted beat
    c2zp_raster u_raster (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (s_accept),
        .image_size (image_size_reg),
        .pos        (pos)
    );

    // line buffer: read the row above at accept, write back when consumed
    c2zp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_SIZE)
    ) u_line_buf (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_pixel_reg),
        .re    (s_accept),
        .raddr (pos.col),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // input stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg   <= s_pixel;
            s1_col_reg     <= pos.col;
            s1_row_nz_reg  <= pos.row_nz;
            s1_col_nz_reg  <= pos.col_nz;
            s1_done_reg    <= pos.done;
            // one-column image: the entry being read is written this very cycle
            s1_fwd_reg     <= s1_adv && (pos.col == s1_col_reg);
            s1_fwd_pix_reg <= s1_pixel_reg;
        end
    end

    assign above_raw = s1_fwd_reg ? s1_fwd_pix_reg : signed'(ram_rdata);

    // ------------------------------------------------------------------
    // neighbor registers, zero after reset
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= '0;
            above_left_reg <= '0;
        end else if (s1_adv) begin
            left_reg       <= s1_pixel_reg;
            above_left_reg <= above_raw;
        end
    end

    assign taps.above_left = above_left_reg;
    assign taps.above      = above_raw;
    assign taps.left       = left_reg;
    assign taps.center     = s1_pixel_reg;
    assign taps.row_nz     = s1_row_nz_reg;
    assign taps.col_nz     = s1_col_nz_reg;

    c2zp_mac u_mac (
        .coefs  (coefs_reg),
        .taps   (taps),
        .result (mac_result)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_filtered_reg <= mac_result;
            m_done_reg     <= s1_done_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_filtered   = m_filtered_reg;
    assign m_image_done = m_done_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a held input stage must block new beats
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |-> !s_ready)
        else $error("input stage overwritten while held");

    // bypass only ever serves column zero
    a_fwd_col0: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_fwd_reg |-> s1_col_reg == '0)
        else $error("line buffer bypass away from column zero");

    // a fresh result always comes out of a full input stage
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a pixel behind it");

endmodule

// ===== test/tb_conv2x2_zero_pad_stream.sv =====
// ----------------------------------------------------------------------------
// tb_conv2x2_zero_pad_stream
// self-checking bench for the streaming 2x2 zero padded convolution
//
// pixels go in over s_ with random gaps and results come out over m_ with
// random stalls. A predictor in the bench keeps its own line buffer, kernel,
// image size and raster position and works out the result of every pixel
// at the edge where the pixel is taken. A monitor compares each result beat
// with the oldest prediction. Directed tests cover the reset setting,
// extreme weights and pixels, sizes zero and one, a size above the line
// buffer, a size that shrinks mid-image and writes to unused register
// indexes; random images with random weights follow.
// ----------------------------------------------------------------------------
module tb_conv2x2_zero_pad_stream;

    import c2zp_pkg::*;

    localparam int STALL_MAX      = 5;     // longest gap or stall per beat
    localparam int DRAIN_CYCLES   = 10;    // drain time after the last beat, with margin
    localparam int WATCHDOG_LIMIT = 1000;  // cycles without any beat
    localparam int RANDOM_PIXELS  = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

    // expected result of one pixel
    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    image_done;
    } conv_result_t;

    // dut ports, all inputs known from time zero
    logic                        aclk       = 1'b0;
    logic                        aresetn    = 1'b0;
    logic                        s_valid    = 1'b0;
    logic                        s_ready;
    logic signed [PIX_W-1:0]     s_pixel    = '0;
    logic                        m_valid;
    logic                        m_ready    = 1'b0;
    logic signed [OUT_W-1:0]     m_filtered;
    logic                        m_image_done;
    logic                        cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index  = '0;
    logic [CFG_DATA_W-1:0]       cfg_data   = '0;

    // predictor state: registers, line buffer, neighbors, raster position
    logic [IMG_W-1:0]            img_size_code;
    coef_set_t                   kernel;
    logic signed [PIX_W-1:0]     line_buf [MAX_SIZE];
    logic signed [PIX_W-1:0]     left_pix;
    logic signed [PIX_W-1:0]     above_left_pix;
    int                          row_pos;
    int                          col_pos;

    conv_result_t                pending_results [$];
    int                          mismatch_count = 0;
    int                          idle_cycles    = 0;
    bit                          burst          = 1'b0;  // no gaps, no stalls

    conv2x2_zero_pad_stream i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered),
        .m_image_done (m_image_done),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // size zero behaves as one, anything past the line buffer as its depth
    function automatic int eff_size(input logic [IMG_W-1:0] code);
        if (code == 0) return 1;
        if (code > MAX_SIZE) return MAX_SIZE;
        return int'(code);
    endfunction

    // 16 bit word, biased toward the extremes and zero
    function automatic logic [PIX_W-1:0] rand_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return '0;
            default: return r[PIX_W-1:0];
        endcase
    endfunction

    // filter output for one pixel at the current raster position; advances
    // the line buffer, the neighbor registers and the counters
    function automatic conv_result_t conv_at_pixel(input logic signed [PIX_W-1:0] pix);
        int                      side;
        logic signed [PIX_W-1:0] above_raw;
        logic signed [PIX_W-1:0] above;
        logic signed [PIX_W-1:0] above_left;
        logic signed [PIX_W-1:0] left;
        longint                  acc;
        conv_result_t            res;
        side       = eff_size(img_size_code);
        above_raw  = line_buf[col_pos];
        above      = '0;
        above_left = '0;
        left       = '0;
        // neighbors outside the image are zero
        if (row_pos != 0) begin
            above = above_raw;
            if (col_pos != 0) above_left = above_left_pix;
        end
        if (col_pos != 0) left = left_pix;
        acc = longint'(kernel.top_left) * longint'(above_left)
            + longint'(kernel.top)      * longint'(above)
            + longint'(kernel.left)     * longint'(left)
            + longint'(kernel.center)   * longint'(pix);
        above_left_pix    = above_raw;
        line_buf[col_pos] = pix;
        left_pix          = pix;
        // counters wrap on >= so a position past a shrunk size wraps at once
        res.image_done = 1'b0;
        if (col_pos + 1 >= side) begin
            col_pos = 0;
            if (row_pos + 1 >= side) begin
                row_pos        = 0;
                res.image_done = 1'b1;
            end else begin
                row_pos = row_pos + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end
        res.filtered = acc[OUT_W-1:0];
        return res;
    endfunction

    // one register write; only called while the filter is empty
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_SIZE:    img_size_code   = data[IMG_W-1:0];
            CFG_COEF_TOP_LEFT: kernel.top_left = data;
            CFG_COEF_TOP:      kernel.top      = data;
            CFG_COEF_LEFT:     kernel.left     = data;
            CFG_COEF_CENTER:   kernel.center   = data;
            default: ;  // unused index, no effect
        endcase
        @(posedge aclk);
    endtask

    // one pixel beat; valid stays up through back to back beats
    task automatic send_pixel(input logic signed [PIX_W-1:0] pix);
        int gap;
        gap = burst ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(conv_at_pixel(pix));
    endtask

    // stop sending and wait for every predicted result to come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // reset setting: 4x4 image, unit weights; cross into the second row
    task automatic test_reset_config();
        burst = 1'b0;
        repeat (6) send_pixel(rand_word());
    endtask

    // shrink to 2 at row 1 column 2: the next pixel wraps both counters
    task automatic test_shrink_mid_image();
        wait_drained();
        write_reg(CFG_IMAGE_SIZE, 16'd2);
        send_pixel(rand_word());
    endtask

    // size one, then size zero with junk above the 11 size bits
    task automatic test_degenerate_sizes();
        wait_drained();
        write_reg(CFG_IMAGE_SIZE, 16'd1);
        repeat (2) send_pixel(rand_word());
        wait_drained();
        write_reg(CFG_IMAGE_SIZE, {5'b10101, 11'd0});
        burst = 1'b1;
        repeat (2) send_pixel(rand_word());
        burst = 1'b0;
    endtask

    // most negative weights times most negative pixels: largest sum
    task automatic test_extreme_weights();
        wait_drained();
        write_reg(CFG_IMAGE_SIZE, 16'd2);
        write_reg(CFG_COEF_TOP_LEFT, 16'h8000);
        write_reg(CFG_COEF_TOP, 16'h8000);
        write_reg(CFG_COEF_LEFT, 16'h8000);
        write_reg(CFG_COEF_CENTER, 16'h8000);
        repeat (4) send_pixel(16'sh8000);
    endtask

    // mixed extreme weights, then zeros written to the unused indexes
    task automatic test_ignored_index();
        wait_drained();
        write_reg(CFG_COEF_TOP_LEFT, 16'h7fff);
        write_reg(CFG_COEF_LEFT, 16'h7fff);
        for (int i = CFG_COEF_CENTER + 1; i <= CFG_IDX_LAST; i++) begin
            write_reg(CFG_IDX_W'(i), '0);
        end
        send_pixel(16'sh7fff);
        send_pixel(16'sh8000);
        send_pixel(16'sh8000);
        send_pixel(16'sh7fff);
    endtask

    // full line buffer width, then a size past it that acts as the depth;
    // one row plus two pixels, then a shrink that ends the image
    task automatic test_oversize_image();
        wait_drained();
        write_reg(CFG_COEF_TOP_LEFT, rand_word());
        write_reg(CFG_COEF_TOP, rand_word());
        write_reg(CFG_COEF_LEFT, rand_word());
        write_reg(CFG_COEF_CENTER, rand_word());
        write_reg(CFG_IMAGE_SIZE, CFG_DATA_W'(MAX_SIZE));
        repeat (5) send_pixel(rand_word());
        wait_drained();
        write_reg(CFG_IMAGE_SIZE, 16'hffff);
        for (int i = 0; i < MAX_SIZE - 3; i++) begin
            if (i % 128 == 0) burst = ($urandom_range(0, 1) == 0);
            send_pixel(rand_word());
        end
        wait_drained();
        burst = 1'b0;
        write_reg(CFG_IMAGE_SIZE, 16'd2);
        send_pixel(rand_word());
    endtask

    // random small images with random weights; mostly whole images, some
    // cut short and at times followed by a size change
    task automatic test_random_images(input int target);
        int                    sent;
        int                    side;
        int                    remaining;
        int                    n_pix;
        logic [IMG_W-1:0]      code;
        logic [CFG_DATA_W-1:0] data;
        sent = 0;
        while (sent < target) begin
            wait_drained();
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_COEF_TOP_LEFT, rand_word());
                write_reg(CFG_COEF_TOP, rand_word());
                write_reg(CFG_COEF_LEFT, rand_word());
                write_reg(CFG_COEF_CENTER, rand_word());
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(CFG_COEF_CENTER + 1, CFG_IDX_LAST)),
                          rand_word());
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 19))
                    0:       code = '0;
                    1:       code = IMG_W'($urandom_range(12, 20));
                    default: code = IMG_W'($urandom_range(1, 9));
                endcase
                // growing is safe only in the first row: later rows would
                // read line buffer entries that were never written
                if (row_pos == 0 || eff_size(code) <= eff_size(img_size_code)) begin
                    data            = CFG_DATA_W'($urandom);
                    data[IMG_W-1:0] = code;
                    write_reg(CFG_IMAGE_SIZE, data);
                end
            end
            side      = eff_size(img_size_code);
            remaining = side * side - row_pos * side - col_pos;
            if (remaining < 1) remaining = 1;
            n_pix = ($urandom_range(0, 4) == 0) ? $urandom_range(1, remaining) : remaining;
            repeat (n_pix) send_pixel(rand_word());
            sent = sent + n_pix;
        end
        burst = 1'b0;
    endtask

    // result monitor: random stall per beat, compare with oldest prediction
    initial begin : result_monitor
        int           stall;
        conv_result_t want;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = burst ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: filtered %0d image_done %b",
                             m_filtered, m_image_done);
            end else begin
                want = pending_results.pop_front();
                if (m_filtered !== want.filtered || m_image_done !== want.image_done) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("mismatch: filtered exp %0d got %0d, image_done exp %b got %b",
                                 want.filtered, m_filtered, want.image_done, m_image_done);
                end
            end
        end
    end

    // watchdog: too long without a beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : test_sequence
        // predictor starts from the reset setting
        img_size_code  = IMAGE_SIZE_RESET;
        kernel         = {4{COEF_RESET}};
        left_pix       = '0;
        above_left_pix = '0;
        row_pos        = 0;
        col_pos        = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_config();
        test_shrink_mid_image();
        test_degenerate_sizes();
        test_extreme_weights();
        test_ignored_index();
        test_oversize_image();
        test_random_images(RANDOM_PIXELS);

        // let any stray beat show up before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== conv2x2_zero_pad_stream.f =====
sv/c2zp_pkg.sv
sv/c2zp_ram.sv
sv/c2zp_raster.sv
sv/c2zp_mac.sv
sv/conv2x2_zero_pad_stream.sv
test/tb_conv2x2_zero_pad_stream.sv
